### rtl/ffha_pkg.sv
// shared types for the first-fit heap allocator: action and status codes
// no dependencies; used by ffha_ctrl and first_fit_heap_allocator
package ffha_pkg;

    // request codes carried on the action field
    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_REALLOC = 2'd2
    } action_t;

    // result codes carried on the status field
    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_NULL    = 3'd1,
        STAT_NOSPACE = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_UNKNOWN = 3'd4
    } status_t;

endpackage

### rtl/ffha_cell.sv
// one cell of the block table chain: holds one packed table entry
// and takes its neighbor's entry on every shift; no package dependency
module ffha_cell #(
    parameter int WIDTH = 49
) (
    input  logic             clk,
    input  logic             shift,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] entry_reg;
    logic [WIDTH-1:0] entry_next;

    // take the neighbor entry while the chain rotates
    always_comb
    begin
        entry_next = entry_reg;
        if (shift)
        begin
            entry_next = d;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

### rtl/ffha_ctrl.sv
// sequencer of the first-fit heap allocator: examines the entry at the chain
// head once per cycle and writes the tail; depends on ffha_pkg
module ffha_ctrl #(
    parameter int MAX_BLOCKS   = 64,
    parameter int ADDR_BITS    = 24,
    parameter int HEADER_BYTES = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             action,
    input  logic [ADDR_BITS-1:0]   request_size,
    input  logic [ADDR_BITS-1:0]   block_address,
    input  logic                   limit_we,
    input  logic [ADDR_BITS-1:0]   limit_data,
    input  logic [2*ADDR_BITS:0]   head_entry,
    output logic                   shift,
    output logic [2*ADDR_BITS:0]   tail_entry,
    output logic                   busy,
    output logic                   done,
    output logic [ADDR_BITS-1:0]   address,
    output ffha_pkg::status_t      status,
    output logic                   reused_block
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W = ADDR_BITS + 2;
    localparam int OFS_W = ADDR_BITS + 1;

    typedef struct packed {
        logic [ADDR_BITS-1:0] blk_start;
        logic [ADDR_BITS-1:0] blk_size;
        logic                 blk_free;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_LOOKUP  = 4'b0010,
        ST_GRANT   = 4'b0100,
        ST_RELEASE = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       step_reg, step_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   hit_reg, hit_next;
    logic                   grow_reg, grow_next;
    logic                   rel_reg, rel_next;
    ffha_pkg::action_t      act_reg, act_next;
    logic [ADDR_BITS-1:0]   req_reg, req_next;
    logic [ADDR_BITS-1:0]   baddr_reg, baddr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [ADDR_BITS-1:0]   top_reg, top_next;
    logic [ADDR_BITS-1:0]   limit_reg, limit_next;
    logic                   done_reg, done_next;
    logic [ADDR_BITS-1:0]   addr_reg, addr_next;
    ffha_pkg::status_t      status_reg, status_next;
    logic                   reused_reg, reused_next;

    entry_t                 head;
    entry_t                 tail;
    logic [CNT_W-1:0]       step_ext;
    logic                   in_use;
    logic                   at_end_slot;
    logic                   is_top;
    logic [OFS_W-1:0]       payload;
    logic [SUM_W-1:0]       need;
    logic                   limit_ok;
    logic                   last_step;
    logic                   lk_hit;
    logic                   lk_fits;
    logic                   rl_hit;
    logic                   release_now;
    logic                   gr_fit;
    logic                   gr_app;
    logic                   hit_now;
    logic                   grow_now;
    logic                   ok_now;

    // head entry decode and per-cycle compares
    always_comb
    begin
        head        = entry_t'(head_entry);
        step_ext    = CNT_W'(step_reg);
        in_use      = step_ext < count_reg;
        at_end_slot = step_ext == count_reg;
        is_top      = (step_ext + CNT_W'(1)) == count_reg;
        payload     = {1'b0, head.blk_start} + OFS_W'(HEADER_BYTES);
        need        = SUM_W'(top_reg) + SUM_W'(HEADER_BYTES) + SUM_W'(req_reg);
        limit_ok    = need <= SUM_W'(limit_reg);
        last_step   = step_reg == IDX_W'(MAX_BLOCKS - 1);
        lk_fits     = head.blk_size >= req_reg;
        lk_hit      = (state_reg == ST_LOOKUP) && !hit_reg && in_use
                      && (payload == {1'b0, baddr_reg});
        rl_hit      = (state_reg == ST_RELEASE) && !hit_reg && (step_reg == idx_reg);
        release_now = (lk_hit && (act_reg == ffha_pkg::ACT_FREE)) || rl_hit;
        gr_fit      = (state_reg == ST_GRANT) && !hit_reg && in_use
                      && head.blk_free && lk_fits;
        gr_app      = (state_reg == ST_GRANT) && !hit_reg && at_end_slot;
        hit_now     = hit_reg || lk_hit;
        grow_now    = grow_reg
                      || (lk_hit && (act_reg == ffha_pkg::ACT_REALLOC) && !lk_fits);
        ok_now      = (hit_reg && (status_reg == ffha_pkg::STAT_OK)) || gr_fit
                      || (gr_app && limit_ok);
    end

    // sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        grow_next   = grow_reg;
        rel_next    = rel_reg;
        act_next    = act_reg;
        req_next    = req_reg;
        baddr_next  = baddr_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        limit_next  = limit_reg;
        done_next   = 1'b0;
        addr_next   = addr_reg;
        status_next = status_reg;
        reused_next = reused_reg;
        tail        = head;

        // configuration write
        if (limit_we)
        begin
            limit_next = limit_data;
        end

        // release of the entry at the head: drop the topmost, else mark free
        if (release_now)
        begin
            if (is_top)
            begin
                count_next = count_reg - CNT_W'(1);
                top_next   = head.blk_start;
            end
            else
            begin
                tail.blk_free = 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (start)
                begin
                    act_next    = ffha_pkg::action_t'(action);
                    req_next    = request_size;
                    baddr_next  = block_address;
                    hit_next    = 1'b0;
                    grow_next   = 1'b0;
                    rel_next    = 1'b0;
                    addr_next   = '0;
                    reused_next = 1'b0;
                    status_next = ffha_pkg::STAT_NULL;
                    unique case (ffha_pkg::action_t'(action))
                        ffha_pkg::ACT_ALLOC:
                        begin
                            if (request_size == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_GRANT;
                            end
                        end
                        ffha_pkg::ACT_FREE:
                        begin
                            if (block_address == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_LOOKUP;
                            end
                        end
                        ffha_pkg::ACT_REALLOC:
                        begin
                            if (request_size == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else if (block_address == '0)
                            begin
                                state_next = ST_GRANT;
                            end
                            else
                            begin
                                state_next = ST_LOOKUP;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_LOOKUP:
            begin
                step_next = last_step ? '0 : step_reg + IDX_W'(1);
                if (lk_hit)
                begin
                    hit_next = 1'b1;
                    idx_next = step_reg;
                    if (act_reg == ffha_pkg::ACT_FREE)
                    begin
                        status_next = ffha_pkg::STAT_OK;
                    end
                    else if (lk_fits)
                    begin
                        status_next = ffha_pkg::STAT_OK;
                        addr_next   = baddr_reg;
                    end
                    else
                    begin
                        grow_next = 1'b1;
                    end
                end
                if (last_step)
                begin
                    if (!hit_now)
                    begin
                        status_next = ffha_pkg::STAT_UNKNOWN;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else if (grow_now)
                    begin
                        hit_next   = 1'b0;
                        rel_next   = 1'b1;
                        state_next = ST_GRANT;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_GRANT:
            begin
                step_next = last_step ? '0 : step_reg + IDX_W'(1);
                // first free block that fits
                if (gr_fit)
                begin
                    tail.blk_free = 1'b0;
                    addr_next     = ADDR_BITS'(payload);
                    reused_next   = 1'b1;
                    status_next   = ffha_pkg::STAT_OK;
                    hit_next      = 1'b1;
                end
                // append at the heap top in the first unused slot
                if (gr_app)
                begin
                    hit_next = 1'b1;
                    if (limit_ok)
                    begin
                        tail.blk_start = top_reg;
                        tail.blk_size  = req_reg;
                        tail.blk_free  = 1'b0;
                        addr_next      = top_reg + ADDR_BITS'(HEADER_BYTES);
                        top_next       = ADDR_BITS'(need);
                        count_next     = count_reg + CNT_W'(1);
                        status_next    = ffha_pkg::STAT_OK;
                    end
                    else
                    begin
                        status_next = ffha_pkg::STAT_NOSPACE;
                    end
                end
                if (last_step)
                begin
                    // table full, no unused slot was reached
                    if (!hit_reg && !gr_fit && !gr_app)
                    begin
                        status_next = limit_ok ? ffha_pkg::STAT_FULL
                                               : ffha_pkg::STAT_NOSPACE;
                    end
                    if (ok_now && rel_reg)
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_RELEASE;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_RELEASE:
            begin
                step_next = last_step ? '0 : step_reg + IDX_W'(1);
                if (rl_hit)
                begin
                    hit_next = 1'b1;
                end
                if (last_step)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            hit_reg   <= 1'b0;
            grow_reg  <= 1'b0;
            rel_reg   <= 1'b0;
            count_reg <= '0;
            top_reg   <= '0;
            limit_reg <= '1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            hit_reg   <= hit_next;
            grow_reg  <= grow_next;
            rel_reg   <= rel_next;
            count_reg <= count_next;
            top_reg   <= top_next;
            limit_reg <= limit_next;
            done_reg  <= done_next;
        end
    end

    // request and result payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        act_reg    <= act_next;
        req_reg    <= req_next;
        baddr_reg  <= baddr_next;
        addr_reg   <= addr_next;
        status_reg <= status_next;
        reused_reg <= reused_next;
    end

    assign shift        = state_reg != ST_IDLE;
    assign tail_entry   = tail;
    assign busy         = state_reg != ST_IDLE;
    assign done         = done_reg;
    assign address      = addr_reg;
    assign status       = status_reg;
    assign reused_block = reused_reg;

    // a result beat only comes out once the sequencer is back at rest
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result beat while a pass is running");

    // the table never holds more entries than it has cells
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("entry count above table depth");

    // chain is aligned whenever the sequencer rests
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (step_reg == '0))
        else $error("chain not aligned at rest");

    // an accepted request either starts a pass or answers at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && (state_reg == ST_IDLE)) |=> (busy || done_reg))
        else $error("accepted request dropped");

    // release pass only follows a move of an existing block
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RELEASE) |-> (rel_reg && (act_reg == ffha_pkg::ACT_REALLOC)))
        else $error("release pass without a pending move");

    // a handed-out freed block is always a success
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && reused_reg) |-> (status_reg == ffha_pkg::STAT_OK))
        else $error("reused block flagged on a failed request");

endmodule

### rtl/first_fit_heap_allocator.sv
// zero size, a null address on free or an unknown action are answered from idle without a pass;
// allocate runs a grant pass, free and reallocate in place a lookup pass; a move that cannot
// be granted runs lookup then grant, and a move of the block runs lookup, grant and release
// each pass turns the block table chain once, one entry past the head per cycle
// a new request is taken in the cycle the result beat is shown; results cannot be stalled
// reset clears entry count and heap top and sets heap_limit to all ones;
// table contents stay undefined until written, entries above the count are never read
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int ADDR_BITS    = 24,
    parameter int HEADER_BYTES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           action,
    input  logic [ADDR_BITS-1:0] request_size,
    input  logic [ADDR_BITS-1:0] block_address,
    output logic                 done,
    output logic [ADDR_BITS-1:0] address,
    output ffha_pkg::status_t    status,
    output logic                 reused_block,
    input  logic                 limit_we,
    input  logic [ADDR_BITS-1:0] limit_data
);

    localparam int ENTRY_W = 2 * ADDR_BITS + 1;

    logic               shift;
    logic [ENTRY_W-1:0] tail_entry;
    logic [ENTRY_W-1:0] cell_q [MAX_BLOCKS];

    // sequencer working on the chain head
    ffha_ctrl #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .ADDR_BITS    (ADDR_BITS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .action        (action),
        .request_size  (request_size),
        .block_address (block_address),
        .limit_we      (limit_we),
        .limit_data    (limit_data),
        .head_entry    (cell_q[0]),
        .shift         (shift),
        .tail_entry    (tail_entry),
        .busy          (busy),
        .done          (done),
        .address       (address),
        .status        (status),
        .reused_block  (reused_block)
    );

    // table chain: each cell takes its upper neighbor, the last takes the tail write
    for (genvar k = 0; k < MAX_BLOCKS; k++)
    begin : g_cell
        logic [ENTRY_W-1:0] cell_d;
        if (k == MAX_BLOCKS - 1)
        begin : g_last
            assign cell_d = tail_entry;
        end
        else
        begin : g_mid
            assign cell_d = cell_q[k+1];
        end

        ffha_cell #(
            .WIDTH (ENTRY_W)
        ) u_cell (
            .clk   (clk),
            .shift (shift),
            .d     (cell_d),
            .q     (cell_q[k])
        );
    end

endmodule

### bench/ffha_checker.sv
// checker for the first-fit heap allocator: watches request and result beats,
// predicts each result from its own heap table copy and compares field by field
// depends on ffha_pkg for the action and status codes
`timescale 1ns / 1ps

module ffha_checker #(
    parameter int MAX_BLOCKS   = 64,
    parameter int ADDR_BITS    = 24,
    parameter int HEADER_BYTES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [1:0]           action,
    input  logic [ADDR_BITS-1:0] request_size,
    input  logic [ADDR_BITS-1:0] block_address,
    input  logic                 done,
    input  logic [ADDR_BITS-1:0] address,
    input  ffha_pkg::status_t    status,
    input  logic                 reused_block,
    input  logic                 limit_we,
    input  logic [ADDR_BITS-1:0] limit_data,
    output int                   fail_count,
    output int                   open_count
);

    typedef logic [ADDR_BITS-1:0] ofs_t;

    typedef struct {
        ofs_t              addr;
        ffha_pkg::status_t st;
        logic              reused;
    } grant_t;

    // shadow heap table
    ofs_t   blk_start [MAX_BLOCKS];
    ofs_t   blk_size  [MAX_BLOCKS];
    logic   blk_free  [MAX_BLOCKS];
    int     blk_count;
    ofs_t   heap_top;
    ofs_t   heap_limit;

    // results still owed by the block, oldest first
    grant_t grants_due[$];
    grant_t next_grant;
    grant_t oldest;

    initial fail_count = 0;

    task automatic flag_mismatch(input string field, input ofs_t want, input ofs_t got);
        $display("%0t ns: %s mismatch, expected %0h got %0h", $time, field, want, got);
        fail_count++;
    endtask

    // table index whose payload offset matches, or -1
    task automatic locate_block(input ofs_t addr, output int idx);
        idx = -1;
        for (int i = 0; i < blk_count; i++)
        begin
            if (idx < 0 && blk_start[i] + HEADER_BYTES == addr)
                idx = i;
        end
    endtask

    // topmost entry leaves the table, any other one is marked free
    task automatic release_block(input int idx);
        if (idx + 1 == blk_count)
        begin
            heap_top = blk_start[idx];
            blk_count--;
        end
        else
        begin
            blk_free[idx] = 1'b1;
        end
    endtask

    // first fit over free entries, else append at the heap top
    task automatic take_space(input ofs_t size, output ofs_t addr,
                              output ffha_pkg::status_t st, output logic reused);
        bit placed;
        addr   = '0;
        reused = 1'b0;
        placed = 0;
        st     = ffha_pkg::STAT_OK;
        if (size == 0)
        begin
            st = ffha_pkg::STAT_NULL;
        end
        else
        begin
            for (int i = 0; i < blk_count; i++)
            begin
                if (!placed && blk_free[i] && blk_size[i] >= size)
                begin
                    blk_free[i] = 1'b0;
                    addr        = ofs_t'(blk_start[i] + HEADER_BYTES);
                    reused      = 1'b1;
                    placed      = 1;
                end
            end
            if (!placed)
            begin
                // limit check ranks above the table-full check
                if (heap_top + HEADER_BYTES + size > heap_limit)
                    st = ffha_pkg::STAT_NOSPACE;
                else if (blk_count >= MAX_BLOCKS)
                    st = ffha_pkg::STAT_FULL;
                else
                begin
                    blk_start[blk_count] = heap_top;
                    blk_size[blk_count]  = size;
                    blk_free[blk_count]  = 1'b0;
                    blk_count++;
                    addr     = ofs_t'(heap_top + HEADER_BYTES);
                    heap_top = ofs_t'(heap_top + HEADER_BYTES + size);
                end
            end
        end
    endtask

    // expected result of one request beat, updating the shadow table
    task automatic predict_request(input logic [1:0] act, input ofs_t size, input ofs_t baddr,
                                   output grant_t g);
        int                idx;
        ofs_t              a;
        ffha_pkg::status_t s;
        logic              r;
        a = '0;
        s = ffha_pkg::STAT_NULL;
        r = 1'b0;
        case (act)
            ffha_pkg::ACT_ALLOC:
                take_space(size, a, s, r);
            ffha_pkg::ACT_FREE:
                if (baddr != 0)
                begin
                    locate_block(baddr, idx);
                    if (idx < 0)
                        s = ffha_pkg::STAT_UNKNOWN;
                    else
                    begin
                        release_block(idx);
                        s = ffha_pkg::STAT_OK;
                    end
                end
            ffha_pkg::ACT_REALLOC:
                if (baddr == 0 || size == 0)
                    take_space(size, a, s, r);
                else
                begin
                    locate_block(baddr, idx);
                    if (idx < 0)
                        s = ffha_pkg::STAT_UNKNOWN;
                    else if (blk_size[idx] >= size)
                    begin
                        a = baddr;
                        s = ffha_pkg::STAT_OK;
                    end
                    else
                    begin
                        // old block only goes once the move succeeded
                        take_space(size, a, s, r);
                        if (s == ffha_pkg::STAT_OK)
                            release_block(idx);
                    end
                end
            default:
                ;
        endcase
        g.addr   = a;
        g.st     = s;
        g.reused = r;
    endtask

    // result beats first, then config writes, then new request beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_count  = 0;
            heap_top   = '0;
            heap_limit = '1;
            grants_due.delete();
            open_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (grants_due.size() == 0)
                    flag_mismatch("unexpected result beat, address", '0, address);
                else
                begin
                    oldest = grants_due.pop_front();
                    if (address !== oldest.addr)
                        flag_mismatch("address", oldest.addr, address);
                    if (status !== oldest.st)
                        flag_mismatch("status", ofs_t'(oldest.st), ofs_t'(status));
                    if (reused_block !== oldest.reused)
                        flag_mismatch("reused_block", ofs_t'(oldest.reused),
                                      ofs_t'(reused_block));
                end
            end
            if (limit_we)
                heap_limit = limit_data;
            if (start && !busy)
            begin
                predict_request(action, request_size, block_address, next_grant);
                grants_due.push_back(next_grant);
            end
            open_count = grants_due.size();
        end
    end

endmodule

### bench/tb.sv
// top of the first-fit heap allocator bench: clock, reset, request stimulus and verdict
// depends on ffha_pkg, first_fit_heap_allocator and ffha_checker
`timescale 1ns / 1ps

module tb;

    localparam int MAX_BLOCKS   = 64;
    localparam int ADDR_BITS    = 24;
    localparam int HEADER_BYTES = 16;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_CYCLES = 3 * MAX_BLOCKS + 16;
    localparam int MAX_GAP      = 40;

    typedef logic [ADDR_BITS-1:0] ofs_t;

    // action code with no operation behind it
    localparam logic [1:0] ACT_UNDEFINED = 2'd3;
    localparam ofs_t LIMIT_MIN = 24'd16;
    localparam ofs_t LIMIT_MAX = '1;

    typedef struct {
        logic [1:0] act;
        ofs_t       baddr;
        bit         from_live;
    } req_rec_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        action;
    ofs_t              request_size;
    ofs_t              block_address;
    logic              done;
    ofs_t              address;
    ffha_pkg::status_t status;
    logic              reused_block;
    logic              limit_we;
    ofs_t              limit_data;

    int fail_count;
    int open_count;
    int cycle_count;
    int idle_pct;

    // payload offsets believed to be held, and requests awaiting their beat
    ofs_t     live_blocks[$];
    req_rec_t in_flight[$];
    req_rec_t done_rec;

    first_fit_heap_allocator #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .ADDR_BITS(ADDR_BITS),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .request_size(request_size),
        .block_address(block_address),
        .done(done),
        .address(address),
        .status(status),
        .reused_block(reused_block),
        .limit_we(limit_we),
        .limit_data(limit_data)
    );

    ffha_checker #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .ADDR_BITS(ADDR_BITS),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_chk (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .request_size(request_size),
        .block_address(block_address),
        .done(done),
        .address(address),
        .status(status),
        .reused_block(reused_block),
        .limit_we(limit_we),
        .limit_data(limit_data),
        .fail_count(fail_count),
        .open_count(open_count)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("first_fit_heap_allocator test failed");
            $finish;
        end
    end

    // track held blocks from result beats so later frees hit real blocks
    always @(posedge clk)
    begin
        if (rst_n && done && in_flight.size() != 0)
        begin
            done_rec = in_flight.pop_front();
            case (done_rec.act)
                ffha_pkg::ACT_ALLOC:
                    if (status == ffha_pkg::STAT_OK)
                        live_blocks.push_back(address);
                ffha_pkg::ACT_REALLOC:
                    if (status == ffha_pkg::STAT_OK)
                        live_blocks.push_back(address);
                    else if (done_rec.from_live)
                        live_blocks.push_back(done_rec.baddr);
                default:
                    ;
            endcase
        end
    end

    // one request beat, after a random idle stretch
    task automatic issue_request(input logic [1:0] act, input ofs_t size, input ofs_t baddr,
                                 input bit from_live);
        int       gap;
        req_rec_t rec;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
            gap++;
        end
        start         <= 1'b1;
        action        <= act;
        request_size  <= size;
        block_address <= baddr;
        while (busy)
            @(negedge clk);
        @(negedge clk);
        rec.act       = act;
        rec.baddr     = baddr;
        rec.from_live = from_live;
        in_flight.push_back(rec);
    endtask

    // hold off until every owed result beat has arrived
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (open_count != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_limit(input ofs_t value);
        limit_we   <= 1'b1;
        limit_data <= value;
        @(negedge clk);
        limit_we <= 1'b0;
    endtask

    // mostly small sizes, a few mid, rare full-range and zero
    function automatic ofs_t pick_size();
        int   r;
        ofs_t sz;
        r = $urandom_range(99);
        if (r < 3)
            sz = '0;
        else if (r < 73)
            sz = ofs_t'($urandom_range(64, 1));
        else if (r < 93)
            sz = ofs_t'($urandom_range(4096, 65));
        else
            sz = ofs_t'($urandom);
        return sz;
    endfunction

    task automatic take_live(output ofs_t a);
        int k;
        k = $urandom_range(live_blocks.size() - 1);
        a = live_blocks[k];
        live_blocks.delete(k);
    endtask

    // well-formed traffic on held blocks plus some noise
    task automatic random_request();
        int         r;
        ofs_t       a;
        ofs_t       sz;
        logic [1:0] act;
        r = $urandom_range(99);
        if (r < 40)
            issue_request(ffha_pkg::ACT_ALLOC, pick_size(), ofs_t'($urandom), 0);
        else if (r < 70)
        begin
            if (live_blocks.size() > 0)
            begin
                take_live(a);
                issue_request(ffha_pkg::ACT_FREE, ofs_t'($urandom), a, 1);
            end
            else
                issue_request(ffha_pkg::ACT_FREE, ofs_t'($urandom), ofs_t'($urandom), 0);
        end
        else if (r < 90)
        begin
            if (live_blocks.size() > 0 && $urandom_range(9) != 0)
            begin
                take_live(a);
                issue_request(ffha_pkg::ACT_REALLOC, pick_size(), a, 1);
            end
            else
                issue_request(ffha_pkg::ACT_REALLOC, pick_size(), '0, 0);
        end
        else
        begin
            act = 2'($urandom_range(3));
            sz  = ofs_t'($urandom);
            // near-miss addresses or fully random ones
            if (live_blocks.size() > 0 && $urandom_range(1) == 1)
                a = live_blocks[$urandom_range(live_blocks.size() - 1)]
                    ^ (ofs_t'(1) << $urandom_range(4));
            else
                a = ofs_t'($urandom);
            issue_request(act, sz, a, 0);
        end
    endtask

    task automatic run_mix(input int pct, input ofs_t lim, input int n);
        wait_drained();
        write_limit(lim);
        idle_pct = pct;
        repeat (n)
            random_request();
    endtask

    // fill the table past full, then hand every block back in random order
    task automatic fill_and_empty();
        ofs_t a;
        wait_drained();
        write_limit(LIMIT_MAX);
        idle_pct = 0;
        repeat (70)
            issue_request(ffha_pkg::ACT_ALLOC, ofs_t'($urandom_range(32, 1)),
                          ofs_t'($urandom), 0);
        issue_request(ffha_pkg::ACT_ALLOC, LIMIT_MAX, '0, 0);
        wait_drained();
        while (live_blocks.size() > 0)
        begin
            take_live(a);
            issue_request(ffha_pkg::ACT_FREE, '0, a, 1);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        action        = ffha_pkg::ACT_ALLOC;
        request_size  = '0;
        block_address = '0;
        limit_we      = 1'b0;
        limit_data    = '0;
        idle_pct      = 0;
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        write_limit(LIMIT_MAX);

        // directed: null cases, unknown blocks, undefined action
        issue_request(ffha_pkg::ACT_ALLOC, '0, '0, 0);
        issue_request(ffha_pkg::ACT_FREE, 24'd5, '0, 0);
        issue_request(ffha_pkg::ACT_FREE, '0, 24'h123456, 0);
        issue_request(ffha_pkg::ACT_REALLOC, 24'd5, 24'd16, 0);
        issue_request(ACT_UNDEFINED, LIMIT_MAX, LIMIT_MAX, 0);
        // grow the heap, hit the limit, reuse a freed middle block
        issue_request(ffha_pkg::ACT_ALLOC, 24'd100, '0, 0);
        issue_request(ffha_pkg::ACT_ALLOC, LIMIT_MAX, '0, 0);
        issue_request(ffha_pkg::ACT_ALLOC, 24'd40, '0, 0);
        issue_request(ffha_pkg::ACT_ALLOC, 24'd8, '0, 0);
        issue_request(ffha_pkg::ACT_FREE, '0, 24'd132, 0);
        issue_request(ffha_pkg::ACT_FREE, '0, 24'd132, 0);
        issue_request(ffha_pkg::ACT_ALLOC, 24'd30, '0, 0);
        // resize in place, move, null-address and zero-size forms
        issue_request(ffha_pkg::ACT_REALLOC, 24'd50, 24'd16, 0);
        issue_request(ffha_pkg::ACT_REALLOC, 24'd200, 24'd16, 0);
        issue_request(ffha_pkg::ACT_REALLOC, 24'd20, '0, 0);
        issue_request(ffha_pkg::ACT_REALLOC, '0, 24'd188, 0);
        // topmost free lowers the top; failed grow keeps the old block
        issue_request(ffha_pkg::ACT_FREE, '0, 24'd212, 0);
        issue_request(ffha_pkg::ACT_REALLOC, LIMIT_MAX, 24'd188, 0);

        // limit below heap top
        wait_drained();
        write_limit(LIMIT_MIN);
        issue_request(ffha_pkg::ACT_ALLOC, 24'd1, '0, 0);
        issue_request(ffha_pkg::ACT_FREE, '0, 24'd188, 0);
        issue_request(ffha_pkg::ACT_ALLOC, 24'd10, '0, 0);
        issue_request(ffha_pkg::ACT_REALLOC, 24'd30, 24'd132, 0);

        fill_and_empty();
        run_mix(83, LIMIT_MAX, 120);
        run_mix(15, 24'd3000, 120);
        run_mix(0, ofs_t'($urandom_range(20000, 500)), 100);
        run_mix(83, LIMIT_MAX, 60);

        wait_drained();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (fail_count == 0 && open_count == 0)
            $display("first_fit_heap_allocator test passed");
        else
            $display("first_fit_heap_allocator test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/ffha_pkg.sv
rtl/ffha_cell.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator.sv
bench/ffha_checker.sv
bench/tb.sv
